### design/jfsc_pkg.sv
// Shared types, constants and a helper function for the joystick frame signal control block.
`timescale 1ns / 1ps

package jfsc_pkg;

    localparam int FRAME_LEN   = 10;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] MARK_A   = 8'hFA;
    localparam logic [7:0] MARK_B   = 8'hFB;
    localparam logic [7:0] MARK_END = 8'hFE;
    localparam logic [7:0] AXIS_LIMIT = 8'd100;
    localparam logic [7:0] SGN_NEG_A  = 8'hFF;
    localparam logic [7:0] SGN_NEG_B  = 8'h01;

    localparam int BTN_LEFT   = 0;
    localparam int BTN_RIGHT  = 1;
    localparam int BTN_HEAD   = 2;
    localparam int BTN_HAZARD = 3;
    localparam int BTN_ZERO   = 4;

    // Input item kinds.
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_STEER = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_NON_FRAME = 3'd0;
    localparam logic [2:0] ST_SUM_OK    = 3'd1;
    localparam logic [2:0] ST_SUM_BAD   = 3'd2;
    localparam logic [2:0] ST_MARKER    = 3'd3;
    localparam logic [2:0] ST_LENGTH    = 3'd4;

    // Turn signal modes.
    localparam logic [1:0] SIG_OFF    = 2'd0;
    localparam logic [1:0] SIG_LEFT   = 2'd1;
    localparam logic [1:0] SIG_RIGHT  = 2'd2;
    localparam logic [1:0] SIG_HAZARD = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_INVERT    = 2'd1;
    localparam logic [1:0] REG_INV_REV   = 2'd2;

    localparam logic [9:0] THRESHOLD_RESET = 10'd60;

    typedef enum logic [1:0] {
        EV_FRAME,
        EV_REJECT,
        EV_STEER,
        EV_STOP
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t           kind;
        logic [2:0]         status;
        logic signed [7:0]  turn;
        logic signed [7:0]  linear;
        logic [7:0]         buttons;
        logic signed [11:0] angle;
    } jfsc_event_t;

    typedef struct packed {
        logic [9:0] threshold;
        logic       invert_turn;
        logic       invert_turn_reversing;
    } jfsc_cfg_t;

    // Sign-plus-magnitude or signed-byte axis, clamped to the axis limit.
    function automatic logic signed [7:0] axis_decode(input logic [7:0] sgn,
                                                      input logic [7:0] mag);
        logic signed [7:0] a;
        if (mag <= AXIS_LIMIT) begin
            if (sgn == SGN_NEG_A || sgn == SGN_NEG_B) begin
                a = -$signed(mag);
            end else begin
                a = $signed(mag);
            end
        end else if (!mag[7]) begin
            a = $signed(AXIS_LIMIT);
        end else if ($signed(mag) < -$signed(AXIS_LIMIT)) begin
            a = -$signed(AXIS_LIMIT);
        end else begin
            a = $signed(mag);
        end
        return a;
    endfunction

endpackage

### design/jfsc_front.sv
// Front end: assembles message bytes, checks the frame and classifies items into events.
`timescale 1ns / 1ps

module jfsc_front
    import jfsc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic [1:0]         op,
    input  logic [7:0]         data_byte,
    input  logic               last_of_message,
    input  logic signed [11:0] wheel_angle,
    output logic               push,
    output jfsc_event_t        event_out
);

    logic [3:0] byte_position_reg, byte_position_next;
    logic [7:0] running_sum_reg, running_sum_next;
    logic [7:0] frame_bytes_reg [FRAME_LEN];

    logic       is_byte;
    logic [3:0] count;

    assign is_byte = accept && (op == OP_BYTE);
    assign count   = (byte_position_reg < 4'd11) ? byte_position_reg + 4'd1
                                                 : byte_position_reg;

    always_comb begin
        byte_position_next = byte_position_reg;
        running_sum_next   = running_sum_reg;
        if (is_byte) begin
            byte_position_next = count;
            if (byte_position_reg < 4'd8) begin
                running_sum_next = running_sum_reg + data_byte;
            end
            if (last_of_message) begin
                byte_position_next = '0;
                running_sum_next   = '0;
            end
        end
    end

    always_comb begin
        event_out.kind    = EV_STOP;
        event_out.status  = ST_NON_FRAME;
        event_out.turn    = axis_decode(frame_bytes_reg[2], frame_bytes_reg[3]);
        event_out.linear  = axis_decode(frame_bytes_reg[4], frame_bytes_reg[5]);
        event_out.buttons = frame_bytes_reg[6];
        event_out.angle   = wheel_angle;
        push              = 1'b0;
        unique case (op)
            OP_BYTE: begin
                push = accept && last_of_message;
                // The final byte is checked straight from the bus, not from storage.
                if (count != 4'(FRAME_LEN)) begin
                    event_out.kind   = EV_REJECT;
                    event_out.status = ST_LENGTH;
                end else if (frame_bytes_reg[0] != MARK_A || frame_bytes_reg[1] != MARK_B ||
                             data_byte != MARK_END) begin
                    event_out.kind   = EV_REJECT;
                    event_out.status = ST_MARKER;
                end else begin
                    event_out.kind   = EV_FRAME;
                    event_out.status = (frame_bytes_reg[8] == running_sum_reg) ? ST_SUM_OK
                                                                               : ST_SUM_BAD;
                end
            end
            OP_STEER: begin
                push           = accept;
                event_out.kind = EV_STEER;
            end
            OP_STOP: begin
                push           = accept;
                event_out.kind = EV_STOP;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg <= '0;
            running_sum_reg   <= '0;
        end else begin
            byte_position_reg <= byte_position_next;
            running_sum_reg   <= running_sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (is_byte && byte_position_reg < 4'(FRAME_LEN)) begin
            frame_bytes_reg[byte_position_reg] <= data_byte;
        end
    end

`ifndef ASSERT_OFF
    assert property (@(posedge aclk) disable iff (!aresetn)
        byte_position_reg <= 4'd11)
        else $error("byte position ran past saturation");

    assert property (@(posedge aclk) disable iff (!aresetn)
        is_byte && last_of_message |=> byte_position_reg == 4'd0 && running_sum_reg == 8'd0)
        else $error("frame assembly did not restart after the last byte");
`endif

endmodule

### design/jfsc_queue.sv
// Short event queue between the front end and the back end.
`timescale 1ns / 1ps

module jfsc_queue
    import jfsc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  jfsc_event_t push_data,
    output logic        full,
    input  logic        pop,
    output logic        valid,
    output jfsc_event_t pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jfsc_event_t entries_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign valid    = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;
    assign pop_data = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef ASSERT_OFF
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue count exceeds depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a lone push");
`endif

endmodule

### design/jfsc_back.sv
// Back end: applies events to the axis, signal and headlight state and holds the result beat.
`timescale 1ns / 1ps

module jfsc_back
    import jfsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  jfsc_cfg_t   cfg,
    input  logic        ev_valid,
    input  jfsc_event_t ev,
    output logic        ev_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  out_status,
    output logic [7:0]  out_linear,
    output logic [7:0]  out_turn,
    output logic [1:0]  out_signal,
    output logic        out_headlights,
    output logic        out_zero_req,
    output logic        out_cancelled
);

    logic [7:0]        prev_buttons_reg, prev_buttons_next;
    logic [1:0]        signal_reg, signal_next;
    logic              headlight_reg, headlight_next;
    logic [1:0]        tracked_reg, tracked_next;
    logic              was_outside_reg, was_outside_next;
    logic signed [7:0] linear_reg, linear_next;
    logic signed [7:0] turn_reg, turn_next;

    logic              m_tvalid_reg;
    logic [2:0]        status_reg;
    logic              zero_req_reg, zero_req_next;
    logic              cancelled_reg, cancelled_next;

    logic [7:0]         pressed;
    logic signed [7:0]  turn_inv;
    logic signed [12:0] angle_ext;
    logic signed [12:0] thr_ext;
    logic               outside_now;

    assign ev_pop    = ev_valid && (!m_tvalid_reg || m_tready);
    assign pressed   = ev.buttons & ~prev_buttons_reg;
    assign angle_ext = 13'(ev.angle);
    assign thr_ext   = $signed({3'b000, cfg.threshold});

    always_comb begin
        turn_inv = cfg.invert_turn ? -ev.turn : ev.turn;
        if (cfg.invert_turn_reversing && ev.linear < 0) begin
            turn_inv = -turn_inv;
        end
    end

    always_comb begin
        if (signal_reg == SIG_LEFT) begin
            outside_now = angle_ext < -thr_ext;
        end else begin
            outside_now = angle_ext > thr_ext;
        end
    end

    always_comb begin
        prev_buttons_next = prev_buttons_reg;
        signal_next       = signal_reg;
        headlight_next    = headlight_reg;
        tracked_next      = tracked_reg;
        was_outside_next  = was_outside_reg;
        linear_next       = linear_reg;
        turn_next         = turn_reg;
        zero_req_next     = 1'b0;
        cancelled_next    = 1'b0;
        unique case (ev.kind)
            EV_FRAME: begin
                linear_next = ev.linear;
                turn_next   = turn_inv;
                // Buttons act in this order, each seeing the mode left by the one before.
                if (pressed[BTN_LEFT]) begin
                    signal_next = (signal_next == SIG_LEFT) ? SIG_OFF : SIG_LEFT;
                end
                if (pressed[BTN_RIGHT]) begin
                    signal_next = (signal_next == SIG_RIGHT) ? SIG_OFF : SIG_RIGHT;
                end
                if (pressed[BTN_HAZARD]) begin
                    signal_next = (signal_next == SIG_HAZARD) ? SIG_OFF : SIG_HAZARD;
                end
                if (pressed[BTN_HEAD]) begin
                    headlight_next = !headlight_reg;
                end
                if (pressed[BTN_ZERO]) begin
                    zero_req_next = 1'b1;
                    linear_next   = '0;
                    turn_next     = '0;
                end
                prev_buttons_next = ev.buttons;
            end
            EV_REJECT: begin
            end
            EV_STEER: begin
                if (signal_reg != SIG_LEFT && signal_reg != SIG_RIGHT) begin
                    tracked_next     = signal_reg;
                    was_outside_next = 1'b0;
                end else begin
                    // Cancel once the wheel comes back inside the threshold.
                    if (signal_reg != tracked_reg) begin
                        tracked_next = signal_reg;
                    end else if (was_outside_reg && !outside_now) begin
                        signal_next    = SIG_OFF;
                        tracked_next   = SIG_OFF;
                        cancelled_next = 1'b1;
                    end
                    was_outside_next = outside_now;
                end
            end
            EV_STOP: begin
                linear_next       = '0;
                turn_next         = '0;
                prev_buttons_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_buttons_reg <= '0;
            signal_reg       <= SIG_OFF;
            headlight_reg    <= 1'b0;
            tracked_reg      <= SIG_OFF;
            was_outside_reg  <= 1'b0;
            linear_reg       <= '0;
            turn_reg         <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (ev_pop) begin
                prev_buttons_reg <= prev_buttons_next;
                signal_reg       <= signal_next;
                headlight_reg    <= headlight_next;
                tracked_reg      <= tracked_next;
                was_outside_reg  <= was_outside_next;
                linear_reg       <= linear_next;
                turn_reg         <= turn_next;
                m_tvalid_reg     <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ev_pop) begin
            status_reg    <= ev.status;
            zero_req_reg  <= zero_req_next;
            cancelled_reg <= cancelled_next;
        end
    end

    assign m_tvalid       = m_tvalid_reg;
    assign out_status     = status_reg;
    assign out_linear     = linear_reg;
    assign out_turn       = turn_reg;
    assign out_signal     = signal_reg;
    assign out_headlights = headlight_reg;
    assign out_zero_req   = zero_req_reg;
    assign out_cancelled  = cancelled_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && cancelled_reg |-> status_reg == ST_NON_FRAME && signal_reg == SIG_OFF)
        else $error("cancel pulse on a beat that is not a steering result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && zero_req_reg |-> linear_reg == 8'sd0 && turn_reg == 8'sd0)
        else $error("zero request left the axes set");
`endif

endmodule

### design/joystick_frame_signal_control.sv
// Top level of the joystick frame signal control block: ports, configuration registers, wiring.
`timescale 1ns / 1ps

// Items arrive on the s_ stream: s_tuser carries the item kind (message byte, steering
// sample, stop), s_tlast marks the final byte of a message. Each closing message byte,
// steering sample and stop gives one result beat on the m_ stream; bytes that are not
// last and unused kinds give none. m_tuser carries the frame status, m_tdata the axes,
// signal mode, headlight state and the two pulses.
// The front end takes one item per cycle while s_tready is high and classifies it into an
// event; a two-entry event queue feeds the back end, which applies one event per cycle into
// the output register while m_tready is high. A result is registered in the queue and then
// in the output register before it shows on m_tvalid; while m_tready is high the block
// sustains one item per cycle. When the receiver stalls, the result is held and the queue
// absorbs up to two more events; s_tready drops only once the queue is full.
// Reset clears the frame assembly, button history, axes, signal and headlight state and
// loads the configuration defaults (threshold 60, both inversions on); pready is always high.
// The user writes the APB port only while the block is idle; the block does not enforce it.
module joystick_frame_signal_control
    import jfsc_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: data_byte [7:0], wheel_angle [19:8], zero pad [23:20]
    input  logic [23:0] s_tdata,
    // s_tuser: op [1:0]
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: linear_axis [7:0], turn_axis [15:8], signal_mode [17:16],
    // headlights_on [18], zero_steer_request [19], signal_cancelled [20], zero pad [23:21]
    output logic [23:0] m_tdata,
    // m_tuser: status [2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    jfsc_cfg_t   cfg_reg;
    jfsc_event_t front_event;
    jfsc_event_t queue_event;
    logic        front_push;
    logic        queue_full;
    logic        queue_valid;
    logic        queue_pop;
    logic        cfg_write;

    logic [2:0]  out_status;
    logic [7:0]  out_linear;
    logic [7:0]  out_turn;
    logic [1:0]  out_signal;
    logic        out_headlights;
    logic        out_zero_req;
    logic        out_cancelled;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign s_tready  = !queue_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold             <= THRESHOLD_RESET;
            cfg_reg.invert_turn           <= 1'b1;
            cfg_reg.invert_turn_reversing <= 1'b1;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_THRESHOLD: cfg_reg.threshold             <= pwdata[9:0];
                REG_INVERT:    cfg_reg.invert_turn           <= pwdata[0];
                REG_INV_REV:   cfg_reg.invert_turn_reversing <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_THRESHOLD: prdata = {22'd0, cfg_reg.threshold};
            REG_INVERT:    prdata = {31'd0, cfg_reg.invert_turn};
            REG_INV_REV:   prdata = {31'd0, cfg_reg.invert_turn_reversing};
            default:       prdata = '0;
        endcase
    end

    jfsc_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (s_tvalid && s_tready),
        .op              (s_tuser),
        .data_byte       (s_tdata[7:0]),
        .last_of_message (s_tlast),
        .wheel_angle     ($signed(s_tdata[19:8])),
        .push            (front_push),
        .event_out       (front_event)
    );

    jfsc_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_push),
        .push_data (front_event),
        .full      (queue_full),
        .pop       (queue_pop),
        .valid     (queue_valid),
        .pop_data  (queue_event)
    );

    jfsc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .ev_valid       (queue_valid),
        .ev             (queue_event),
        .ev_pop         (queue_pop),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .out_status     (out_status),
        .out_linear     (out_linear),
        .out_turn       (out_turn),
        .out_signal     (out_signal),
        .out_headlights (out_headlights),
        .out_zero_req   (out_zero_req),
        .out_cancelled  (out_cancelled)
    );

    assign m_tuser = out_status;
    assign m_tdata = {3'b000, out_cancelled, out_zero_req, out_headlights, out_signal,
                      out_turn, out_linear};

endmodule

### sim/joystick_frame_signal_control_test.sv
// Self-checking testbench for the joystick frame signal control block.
`timescale 1ns / 1ps

module joystick_frame_signal_control_test;
    import jfsc_pkg::*;

    localparam logic [1:0] OP_UNUSED       = 2'd3;
    localparam int         AXIS_MAX        = 100;
    localparam int         ANGLE_MAX       = 1800;
    localparam int         WATCHDOG_LIMIT  = 3000;
    localparam int         DRAIN_CYCLES    = 8;
    localparam int         PRESSURE_CYCLES = 80;
    localparam int         PHASE_ITEMS     = 250;

    typedef logic [7:0] byte_q_t[$];

    typedef struct {
        logic [2:0]        status;
        logic signed [7:0] linear;
        logic signed [7:0] turn;
        logic [1:0]        mode;
        logic              lights;
        logic              zero_req;
        logic              cancelled;
    } control_beat_t;

    // Tracks the frame assembly and the signal/headlight state, and holds the
    // result beats still owed by the block.
    class signal_scoreboard;
        logic [9:0]        threshold;
        logic              invert;
        logic              invert_rev;
        int unsigned       byte_count;
        logic [7:0]        sum;
        logic [7:0]        frame_buf [FRAME_LEN];
        logic [7:0]        held_buttons;
        logic [1:0]        mode;
        logic [1:0]        tracked;
        logic              lights;
        logic              outside_seen;
        logic signed [7:0] linear;
        logic signed [7:0] turn;
        control_beat_t     expected_beats[$];
        int unsigned       beats_seen;

        function new();
            threshold    = THRESHOLD_RESET;
            invert       = 1'b1;
            invert_rev   = 1'b1;
            byte_count   = 0;
            sum          = '0;
            held_buttons = '0;
            mode         = SIG_OFF;
            tracked      = SIG_OFF;
            lights       = 1'b0;
            outside_seen = 1'b0;
            linear       = '0;
            turn         = '0;
            beats_seen   = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_THRESHOLD: threshold  = value[9:0];
                REG_INVERT:    invert     = value[0];
                REG_INV_REV:   invert_rev = value[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function void push_beat(logic [2:0] status, logic zero_req, logic cancelled);
            control_beat_t b;
            b = '{status, linear, turn, mode, lights, zero_req, cancelled};
            expected_beats.push_back(b);
        endfunction

        // Magnitudes above the limit are taken as a signed byte, then clamped.
        function int decode_axis(logic [7:0] sgn, logic [7:0] mag);
            int a;
            if (mag <= AXIS_LIMIT) begin
                a = int'(mag);
                if (sgn == SGN_NEG_A || sgn == SGN_NEG_B) a = -a;
            end else begin
                a = int'($signed(mag));
            end
            if (a > AXIS_MAX) a = AXIS_MAX;
            if (a < -AXIS_MAX) a = -AXIS_MAX;
            return a;
        endfunction

        function logic [1:0] toggled(logic [1:0] target);
            return (mode == target) ? SIG_OFF : target;
        endfunction

        function void close_message();
            int          x;
            int          y;
            int unsigned count;
            logic [7:0]  frame_sum;
            logic [7:0]  pressed;
            logic        zero_req;
            count      = byte_count;
            frame_sum  = sum;
            byte_count = 0;
            sum        = '0;
            if (count != FRAME_LEN) begin
                push_beat(ST_LENGTH, 1'b0, 1'b0);
            end else if (frame_buf[0] != MARK_A || frame_buf[1] != MARK_B ||
                         frame_buf[9] != MARK_END) begin
                push_beat(ST_MARKER, 1'b0, 1'b0);
            end else begin
                x = decode_axis(frame_buf[2], frame_buf[3]);
                y = decode_axis(frame_buf[4], frame_buf[5]);
                if (invert) x = -x;
                if (invert_rev && y < 0) x = -x;
                linear   = 8'(y);
                turn     = 8'(x);
                pressed  = frame_buf[6] & ~held_buttons;
                zero_req = 1'b0;
                if (pressed[BTN_LEFT])   mode = toggled(SIG_LEFT);
                if (pressed[BTN_RIGHT])  mode = toggled(SIG_RIGHT);
                if (pressed[BTN_HEAD])   lights = ~lights;
                if (pressed[BTN_HAZARD]) mode = toggled(SIG_HAZARD);
                if (pressed[BTN_ZERO]) begin
                    zero_req = 1'b1;
                    linear   = '0;
                    turn     = '0;
                end
                held_buttons = frame_buf[6];
                push_beat((frame_buf[8] == frame_sum) ? ST_SUM_OK : ST_SUM_BAD, zero_req,
                          1'b0);
            end
        endfunction

        // A left or right signal is cancelled once the wheel has been beyond the
        // threshold in its direction and then comes back inside it.
        function void steer(logic signed [11:0] angle);
            int   ang;
            int   thr;
            logic outside;
            logic cancelled;
            ang       = angle;
            thr       = int'(threshold);
            cancelled = 1'b0;
            if (mode != SIG_LEFT && mode != SIG_RIGHT) begin
                tracked      = mode;
                outside_seen = 1'b0;
            end else begin
                outside = (mode == SIG_LEFT) ? (ang < -thr) : (ang > thr);
                if (mode != tracked) begin
                    tracked = mode;
                end else if (outside_seen && !outside) begin
                    mode      = SIG_OFF;
                    tracked   = SIG_OFF;
                    cancelled = 1'b1;
                end
                outside_seen = outside;
            end
            push_beat(ST_NON_FRAME, 1'b0, cancelled);
        endfunction

        function void note_item(logic [1:0] op, logic [7:0] data, logic is_last,
                                logic signed [11:0] angle);
            case (op)
                OP_BYTE: begin
                    if (byte_count < FRAME_LEN) frame_buf[byte_count] = data;
                    if (byte_count < 8) sum += data;
                    if (byte_count < FRAME_LEN + 1) byte_count++;
                    if (is_last) close_message();
                end
                OP_STEER: steer(angle);
                OP_STOP: begin
                    linear       = '0;
                    turn         = '0;
                    held_buttons = '0;
                    push_beat(ST_NON_FRAME, 1'b0, 1'b0);
                end
                default: ;
            endcase
        endfunction

        function string check_beat(logic [2:0] status, logic [23:0] data);
            control_beat_t e;
            string         msg;
            msg = "";
            beats_seen++;
            if (expected_beats.size() == 0)
                return $sformatf("result beat %0d arrived with nothing expected", beats_seen);
            e = expected_beats.pop_front();
            if (status !== e.status)
                msg = {msg, $sformatf(" status %0d/%0d", status, e.status)};
            if (data[7:0] !== e.linear)
                msg = {msg, $sformatf(" linear %0d/%0d", $signed(data[7:0]), e.linear)};
            if (data[15:8] !== e.turn)
                msg = {msg, $sformatf(" turn %0d/%0d", $signed(data[15:8]), e.turn)};
            if (data[17:16] !== e.mode)
                msg = {msg, $sformatf(" signal %0d/%0d", data[17:16], e.mode)};
            if (data[18] !== e.lights)
                msg = {msg, $sformatf(" lights %0d/%0d", data[18], e.lights)};
            if (data[19] !== e.zero_req)
                msg = {msg, $sformatf(" zero_req %0d/%0d", data[19], e.zero_req)};
            if (data[20] !== e.cancelled)
                msg = {msg, $sformatf(" cancelled %0d/%0d", data[20], e.cancelled)};
            if (msg != "")
                msg = $sformatf("result beat %0d mismatch (got/exp):%s", beats_seen, msg);
            return msg;
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic [23:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = OP_BYTE;
    logic        s_tlast  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    signal_scoreboard board = new();

    int    error_count  = 0;
    int    stall_cycles = 0;
    int    items_sent   = 0;
    int    burst_left   = 0;
    int    gapless_left = 0;
    bit    hold_off_req = 1'b0;
    string beat_msg;

    joystick_frame_signal_control DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        error_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            beat_msg = board.check_beat(m_tuser, m_tdata);
            if (beat_msg != "") report_mismatch(beat_msg);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("** joystick_frame_signal_control: FAILED **");
            $finish;
        end
    end

    // Result side: ready follows a changing pattern, with one long hold-off on request.
    initial begin : result_sink
        int style;
        int style_left;
        int tick;
        style_left = 0;
        tick       = 0;
        style      = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
            end else begin
                if (style_left == 0) begin
                    style      = $urandom_range(0, 3);
                    style_left = $urandom_range(10, 80);
                end
                style_left--;
                tick++;
                case (style)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= ((tick % 3) != 0);
                    default: m_tready <= ($urandom_range(0, 1) == 1);
                endcase
            end
        end
    end

    function automatic logic signed [11:0] any_angle();
        return 12'(int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX);
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [7:0] data, input logic is_last,
                             input logic signed [11:0] angle);
        int gap;
        if (gapless_left > 0) begin
            gapless_left--;
        end else if (burst_left == 0) begin
            burst_left = $urandom_range(0, 23);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end else begin
            burst_left--;
        end
        @(negedge aclk);
        s_tdata  <= {4'b0, angle, data};
        s_tuser  <= op;
        s_tlast  <= is_last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        board.note_item(op, data, is_last, angle);
        if (op != OP_UNUSED) items_sent++;
    endtask

    task automatic send_bytes(input byte_q_t msg);
        foreach (msg[i])
            send_item(OP_BYTE, msg[i], i == msg.size() - 1, any_angle());
    endtask

    task automatic send_steer(input logic signed [11:0] angle);
        send_item(OP_STEER, 8'($urandom), 1'($urandom), angle);
    endtask

    task automatic send_stop();
        send_item(OP_STOP, 8'($urandom), 1'($urandom), any_angle());
    endtask

    function automatic byte_q_t make_frame(input logic [7:0] xs, input logic [7:0] xv,
                                           input logic [7:0] ys, input logic [7:0] yv,
                                           input logic [7:0] btn, input bit good_sum);
        byte_q_t    f;
        logic [7:0] s;
        f = {MARK_A, MARK_B, xs, xv, ys, yv, btn, 8'($urandom)};
        s = '0;
        foreach (f[i]) s += f[i];
        f.push_back(good_sum ? s : s ^ (8'd1 << $urandom_range(0, 7)));
        f.push_back(MARK_END);
        return f;
    endfunction

    function automatic logic [7:0] random_sign();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return SGN_NEG_A;
            2:       return SGN_NEG_B;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] random_mag();
        if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, AXIS_MAX));
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] random_buttons();
        if ($urandom_range(0, 9) == 0) return 8'($urandom);
        return 8'($urandom_range(0, 31));
    endfunction

    function automatic byte_q_t random_frame(input bit good_sum);
        return make_frame(random_sign(), random_mag(), random_sign(), random_mag(),
                          random_buttons(), good_sum);
    endfunction

    // Angles are aimed around the threshold so that signals get cancelled.
    task automatic steering_run();
        int n;
        int thr;
        int mag;
        n   = $urandom_range(2, 6);
        thr = int'(board.threshold);
        repeat (n) begin
            case ($urandom_range(0, 3))
                0:       mag = $urandom_range(thr + 1, ANGLE_MAX);
                1:       mag = $urandom_range(0, thr);
                2:       mag = thr;
                default: mag = $urandom_range(0, ANGLE_MAX);
            endcase
            send_steer(12'($urandom_range(0, 1) ? -mag : mag));
        end
    endtask

    task automatic random_traffic(input int count);
        int      target;
        int      pick;
        int      len;
        byte_q_t msg;
        target = items_sent + count;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                send_bytes(random_frame($urandom_range(0, 6) != 0));
            end else if (pick < 58) begin
                msg = random_frame(1'b1);
                case ($urandom_range(0, 2))
                    0:       msg[0] = msg[0] ^ 8'($urandom_range(1, 255));
                    1:       msg[1] = msg[1] ^ 8'($urandom_range(1, 255));
                    default: msg[9] = msg[9] ^ 8'($urandom_range(1, 255));
                endcase
                send_bytes(msg);
            end else if (pick < 66) begin
                msg = random_frame(1'b1);
                len = $urandom_range(0, 1) ? $urandom_range(1, FRAME_LEN - 1)
                                           : $urandom_range(FRAME_LEN + 1, FRAME_LEN + 4);
                while (msg.size() > len) void'(msg.pop_back());
                while (msg.size() < len) msg.push_back(8'($urandom));
                send_bytes(msg);
            end else if (pick < 88) begin
                steering_run();
            end else if (pick < 95) begin
                send_stop();
            end else begin
                send_item(OP_UNUSED, 8'($urandom), 1'($urandom), any_angle());
            end
        end
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        board.write_reg(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic [9:0] thr, input logic inv, input logic inv_rev);
        write_register(REG_THRESHOLD, {22'b0, thr});
        write_register(REG_INVERT, {31'b0, inv});
        write_register(REG_INV_REV, {31'b0, inv_rev});
    endtask

    // Bytes that are not last give no result, so a drain wait follows the last
    // expected beat before the block is taken as idle.
    task automatic wait_until_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic directed_items();
        send_bytes(make_frame(8'h00, 8'h00, SGN_NEG_A, 8'd100, 8'h05, 1'b1));
        send_steer(12'(ANGLE_MAX));
        send_steer(12'(-ANGLE_MAX));
        send_steer(12'(0));
        send_stop();
        send_item(OP_UNUSED, 8'hFF, 1'b1, 12'(-1));
        send_bytes({8'hFF});
        send_bytes(make_frame(SGN_NEG_B, 8'h90, 8'h00, 8'hFF, 8'h18, 1'b0));
    endtask

    task automatic receiver_pressure();
        hold_off_req = 1'b1;
        gapless_left = 40;
        repeat (20) begin
            send_steer(any_angle());
            send_stop();
        end
    endtask

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        directed_items();
        random_traffic(PHASE_ITEMS);

        wait_until_idle();
        configure(10'd0, 1'b0, 1'b0);
        random_traffic(PHASE_ITEMS);

        wait_until_idle();
        configure(10'd900, 1'b1, 1'b0);
        receiver_pressure();
        random_traffic(PHASE_ITEMS);

        wait_until_idle();
        configure(10'($urandom_range(0, 900)), 1'b0, 1'b1);
        random_traffic(PHASE_ITEMS);

        wait_until_idle();
        configure(10'($urandom_range(0, 900)), 1'($urandom), 1'($urandom));
        random_traffic(PHASE_ITEMS);

        wait_until_idle();
        configure(THRESHOLD_RESET, 1'b1, 1'b1);
        random_traffic(PHASE_ITEMS);

        wait_until_idle();
        if (error_count == 0) begin
            $display("** joystick_frame_signal_control: PASSED **");
        end else begin
            $display("** joystick_frame_signal_control: FAILED **");
        end
        $finish;
    end

endmodule
